// ===== rtl/hfps_pkg.sv =====
// ----------------------------------------------------------------------------
// hfps_pkg: shared types and constants for the half float to sRGB8 unit
// Threshold table for the sRGB curve, built at elaboration, plus lane widths.
// ----------------------------------------------------------------------------
package hfps_pkg;

  localparam int ENCODE_TABLE_BITS = 12;
  localparam int LIN_W     = ENCODE_TABLE_BITS + 1;
  localparam int THR_SHIFT = 32 - ENCODE_TABLE_BITS;

  localparam int CHAN_W    = 16;
  localparam int CODE_W    = 8;
  localparam int N_CODES   = 1 << CODE_W;
  localparam int MANT_W    = 11;
  localparam int WS_W      = 26;
  localparam int PROD_W    = MANT_W + WS_W;
  localparam int EXP_W     = 5;
  localparam int SHL_MAX   = 29;
  localparam int SUM_W     = PROD_W + SHL_MAX + 1;
  localparam int DROP      = 40 - ENCODE_TABLE_BITS;
  localparam int Q_W       = SUM_W - DROP;

  localparam int SEARCH_STEPS = CODE_W;
  localparam int NSTG         = 2 + SEARCH_STEPS;

  localparam int CFG_AW = 2;

  typedef enum logic [CFG_AW-1:0] {
    CFG_HDR_MODE    = 2'd0,
    CFG_SWAP_RB     = 2'd1,
    CFG_WHITE_SCALE = 2'd2
  } cfg_idx_t;

  localparam logic [WS_W-1:0] WHITE_SCALE_RST = WS_W'(65536);

  typedef logic [N_CODES-1:0][LIN_W-1:0] thr_tab_t;

  typedef struct packed {
    logic              hdr;
    logic              last;
    logic [CODE_W-1:0] red;
    logic [CODE_W-1:0] green;
    logic [CODE_W-1:0] blue;
  } sb_t;

  function automatic logic [63:0] pow5_q32(logic [63:0] y);
    logic [63:0] a;
    a = y;
    for (int i = 0; i < 4; i++) begin
      a = (a * y) >> 32;
    end
    return a;
  endfunction

  function automatic thr_tab_t build_thr();
    thr_tab_t    tab;
    logic [63:0] odd;
    logic [63:0] num;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] t;
    tab = '0;
    for (int k = 1; k < N_CODES; k++) begin
      odd = 64'(2 * k - 1);
      if (k <= 10) begin
        num = (odd * 64'd100) << 32;
        t   = (num + 64'd329460) / 64'd658920;
      end else begin
        num = odd * 64'd1000 + 64'd28050;
        x   = ((num << 32) + 64'd269025) / 64'd538050;
        x2  = (x * x + 64'h8000_0000) >> 32;
        lo  = 64'd0;
        hi  = 64'd1 << 32;
        for (int i = 0; i < 40; i++) begin
          if (hi - lo > 64'd1) begin
            mid = lo + ((hi - lo) >> 1);
            if (pow5_q32(mid) <= x2) lo = mid;
            else hi = mid;
          end
        end
        t = (x2 * lo + 64'h8000_0000) >> 32;
      end
      tab[k] = LIN_W'((t + (64'd1 << THR_SHIFT) - 64'd1) >> THR_SHIFT);
    end
    return tab;
  endfunction

  localparam thr_tab_t THR_TAB = build_thr();

endpackage

// ===== rtl/hfps_lane.sv =====
// ----------------------------------------------------------------------------
// hfps_lane: one channel of the HDR encoder
// Half decode and white scaling, rounding to linear fixed point, then an
// eight step pipelined binary search over the sRGB decision thresholds.
// ----------------------------------------------------------------------------
module hfps_lane
  import hfps_pkg::*;
(
  input  logic              clk,
  input  logic [NSTG-1:0]   en,
  input  logic [CHAN_W-1:0] chan,
  input  logic [WS_W-1:0]   white_scale,
  output logic [CODE_W-1:0] code
);

  localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << ENCODE_TABLE_BITS;

  // stage 0: decode and multiply
  logic [EXP_W-1:0]   exp_w;
  logic [MANT_W-1:0]  mant;
  logic [PROD_W-1:0]  prod_nxt;
  logic [PROD_W-1:0]  prod_r;
  logic [EXP_W-1:0]   shl_nxt;
  logic [EXP_W-1:0]   shl_r;
  logic               kill_nxt;
  logic               kill_r;

  assign exp_w    = chan[14:10];
  assign mant     = {(exp_w != '0), chan[9:0]};
  assign prod_nxt = PROD_W'(mant) * PROD_W'(white_scale);
  assign shl_nxt  = (exp_w == '0) ? '0 : exp_w - EXP_W'(1);
  assign kill_nxt = chan[15] | (exp_w == '1);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_r <= prod_nxt;
      shl_r  <= shl_nxt;
      kill_r <= kill_nxt;
    end
  end

  // stage 1: align, round half up, saturate to 1.0; negative, Inf and NaN give zero
  logic [SUM_W-1:0] shifted;
  logic [SUM_W-1:0] rounded;
  logic [Q_W-1:0]   q;
  logic [LIN_W-1:0] lin_nxt;
  logic [LIN_W-1:0] lin_r;

  assign shifted = SUM_W'(prod_r) << shl_r;
  assign rounded = shifted + (SUM_W'(1) << (DROP - 1));
  assign q       = rounded[SUM_W-1:DROP];

  always_comb begin
    if (kill_r) begin
      lin_nxt = '0;
    end else if (q > ONE_Q) begin
      lin_nxt = LIN_W'(ONE_Q);
    end else begin
      lin_nxt = LIN_W'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      lin_r <= lin_nxt;
    end
  end

  // stages 2..: binary search, one code bit per stage
  logic [CODE_W-1:0] cur_r   [SEARCH_STEPS];
  logic [LIN_W-1:0]  lin_s_r [SEARCH_STEPS-1];

  for (genvar j = 0; j < SEARCH_STEPS; j++) begin : g_step
    localparam logic [CODE_W-1:0] STEP_BIT = CODE_W'(1) << (SEARCH_STEPS - 1 - j);
    logic [LIN_W-1:0]  lin_in;
    logic [CODE_W-1:0] cur_in;
    logic [CODE_W-1:0] cand;
    logic [CODE_W-1:0] cur_nxt;

    if (j == 0) begin : g_first
      assign lin_in = lin_r;
      assign cur_in = '0;
    end else begin : g_next
      assign lin_in = lin_s_r[j-1];
      assign cur_in = cur_r[j-1];
    end

    assign cand    = cur_in | STEP_BIT;
    assign cur_nxt = (lin_in >= THR_TAB[cand]) ? cand : cur_in;

    always_ff @(posedge clk) begin
      if (en[2+j]) begin
        cur_r[j] <= cur_nxt;
      end
    end

    if (j < SEARCH_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[2+j]) begin
          lin_s_r[j] <= lin_in;
        end
      end
    end
  end

  assign code = cur_r[SEARCH_STEPS-1];

endmodule

// ===== rtl/half_float_pixel_to_srgb8_unit.sv =====
// ----------------------------------------------------------------------------
// half_float_pixel_to_srgb8_unit: pixel stream to 8-bit sRGB
// Three encoder lanes in HDR mode, byte pass-through with optional red/blue
// swap in SDR mode; merged into a registered output beat.
// ----------------------------------------------------------------------------
// Throughput: one pixel per clock unless out_tready stalls the output; the
//   ten-stage lane pipeline and the output register collapse bubbles, so a
//   stall holds only full stages.
// Reset: hdr_mode = 0, swap_red_blue = 0, white_scale = 1.0, pipeline empty.
//   Threshold table is a constant, no fill pass after reset.
module half_float_pixel_to_srgb8_unit
  import hfps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              cfg_wen,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [WS_W-1:0]   cfg_wdata,

  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [47:0]       in_tdata,   // chan0 [15:0], chan1 [31:16], chan2 [47:32]
  input  logic              in_tlast,

  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,  // red [7:0], green [15:8], blue [23:16]
  output logic              out_tlast
);

  // config registers
  logic            hdr_mode_r;
  logic            swap_rb_r;
  logic [WS_W-1:0] white_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_mode_r    <= 1'b0;
      swap_rb_r     <= 1'b0;
      white_scale_r <= WHITE_SCALE_RST;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        CFG_HDR_MODE:    hdr_mode_r    <= cfg_wdata[0];
        CFG_SWAP_RB:     swap_rb_r     <= cfg_wdata[0];
        CFG_WHITE_SCALE: white_scale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage enables
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] en;
  logic            out_en;
  logic            in_fire;

  assign out_en = !out_tvalid || out_tready;

  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_en;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_tready = en[0];
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_fire;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // sideband: mode, tlast and SDR bytes
  logic [CHAN_W-1:0] chan0;
  logic [CHAN_W-1:0] chan1;
  logic [CHAN_W-1:0] chan2;
  sb_t               sb_nxt;
  sb_t               sb_r [NSTG];

  assign chan0 = in_tdata[15:0];
  assign chan1 = in_tdata[31:16];
  assign chan2 = in_tdata[47:32];

  always_comb begin
    sb_nxt.hdr   = hdr_mode_r;
    sb_nxt.last  = in_tlast;
    sb_nxt.red   = swap_rb_r ? chan2[7:0] : chan0[7:0];
    sb_nxt.green = chan1[7:0];
    sb_nxt.blue  = swap_rb_r ? chan0[7:0] : chan2[7:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) sb_r[0] <= sb_nxt;
    for (int i = 1; i < NSTG; i++) begin
      if (en[i]) sb_r[i] <= sb_r[i-1];
    end
  end

  // encoder lanes
  logic [CODE_W-1:0] code0;
  logic [CODE_W-1:0] code1;
  logic [CODE_W-1:0] code2;

  hfps_lane u_lane0 (
    .clk         (clk),
    .en          (en),
    .chan        (chan0),
    .white_scale (white_scale_r),
    .code        (code0)
  );

  hfps_lane u_lane1 (
    .clk         (clk),
    .en          (en),
    .chan        (chan1),
    .white_scale (white_scale_r),
    .code        (code1)
  );

  hfps_lane u_lane2 (
    .clk         (clk),
    .en          (en),
    .chan        (chan2),
    .white_scale (white_scale_r),
    .code        (code2)
  );

  // merge and output register
  sb_t         last_sb;
  logic [23:0] data_nxt;
  logic        out_tvalid_r;
  logic [23:0] out_tdata_r;
  logic        out_tlast_r;

  assign last_sb  = sb_r[NSTG-1];
  assign data_nxt = last_sb.hdr ? {code2, code1, code0}
                                : {last_sb.blue, last_sb.green, last_sb.red};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_en) begin
      out_tvalid_r <= vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_tdata_r <= data_nxt;
      out_tlast_r <= last_sb.last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // checks
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> ((&vld_r) && out_tvalid))
    else $error("input stalled with a free pipeline stage");

  a_first_stage_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(vld_r[0]) |-> $past(in_tvalid && in_tready))
    else $error("first stage filled without an input beat");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(vld_r[NSTG-1]))
    else $error("output beat without a pipeline item");

endmodule
